// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the breaker RTL; empty when synthesizing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked check, disabled while reset is asserted (active low).
`define CSB_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked check that also runs through reset.
`define CSB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define CSB_ASSERT(lbl, clk, rstn, prop, msg)
`define CSB_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ----- hw/rtl/csb_pkg.sv -----
// Types and constants for the per-service circuit breaker.
package csb_pkg;

    // Field widths of the stream words
    localparam int MODE_W     = 2;
    localparam int SVC_ID_W   = 4;
    localparam int TIME_W     = 32;
    localparam int COUNT_W    = 8;
    localparam int STATE_W    = 2;
    localparam int LIMIT_W    = 8;
    localparam int TIMEOUT_W  = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 40;  // service_id + now_seconds, padded to bytes
    localparam int M_TDATA_W  = 24;  // allow + state + fails + successes, padded

    // Highest service count that a service_id can address
    localparam int MAX_SERVICES = 2 ** SVC_ID_W;

    // Reset values of the configuration registers
    localparam logic [LIMIT_W-1:0]   FAIL_LIMIT_RST   = 8'd3;
    localparam logic [TIMEOUT_W-1:0] OPEN_TIMEOUT_RST = 16'd30;
    localparam logic [LIMIT_W-1:0]   CLOSE_LIMIT_RST  = 8'd5;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [MODE_W-1:0] {
        MODE_CHECK   = 2'd0,
        MODE_FAIL    = 2'd1,
        MODE_SUCCESS = 2'd2
    } mode_t;

    typedef enum logic [STATE_W-1:0] {
        ST_CLOSED  = 2'd0,
        ST_HALF    = 2'd1,
        ST_OPEN    = 2'd2,
        ST_UNKNOWN = 2'd3
    } brk_state_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_FAIL_LIMIT   = 2'd0,
        CFG_OPEN_TIMEOUT = 2'd1,
        CFG_CLOSE_LIMIT  = 2'd2
    } cfg_addr_t;

    // One stored breaker entry (the known flag lives beside it)
    typedef struct packed {
        brk_state_t          state;
        logic [COUNT_W-1:0]  fails;
        logic [COUNT_W-1:0]  successes;
        logic [TIME_W-1:0]   changed_at;
    } entry_t;

    typedef struct packed {
        logic [LIMIT_W-1:0]   fail_limit;
        logic [TIMEOUT_W-1:0] open_timeout;
        logic [LIMIT_W-1:0]   close_limit;
    } cfg_t;

    // Table write request from the update logic
    typedef struct packed {
        logic   en;
        entry_t entry;
    } tbl_wr_t;

    typedef struct packed {
        logic               allow;
        brk_state_t         state;
        logic [COUNT_W-1:0] fails;
        logic [COUNT_W-1:0] successes;
    } result_t;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        return (v == COUNT_MAX) ? COUNT_MAX : v + 1'b1;
    endfunction

endpackage

// ----- hw/rtl/csb_table.sv -----
// Breaker entry table: flip-flop rows, one combinational read and one write port.
module csb_table #(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [IDX_W-1:0]     rd_idx,
    output logic                 rd_known,
    output csb_pkg::entry_t      rd_entry,
    input  logic [IDX_W-1:0]     wr_idx,
    input  csb_pkg::tbl_wr_t     wr
);

    logic            known_reg [DEPTH];
    csb_pkg::entry_t entry_reg [DEPTH];

    // Read at the index of the item in the input register
    assign rd_known = known_reg[rd_idx];
    assign rd_entry = entry_reg[rd_idx];

    // Known flags clear at reset; entry payload needs none
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) begin
                known_reg[i] <= 1'b0;
            end
        end else if (wr.en) begin
            known_reg[wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            entry_reg[wr_idx] <= wr.entry;
        end
    end

endmodule

// ----- hw/rtl/csb_update.sv -----
// Next-entry and result logic for one breaker request.
module csb_update (
    input  logic                          in_range,
    input  csb_pkg::mode_t                mode,
    input  logic [csb_pkg::TIME_W-1:0]    now,
    input  csb_pkg::cfg_t                 cfg,
    input  logic                          rd_known,
    input  csb_pkg::entry_t               rd_entry,
    output csb_pkg::tbl_wr_t              wr,
    output csb_pkg::result_t              result
);

    logic [csb_pkg::TIME_W-1:0]  elapsed;
    logic                        timed_out;
    logic [csb_pkg::COUNT_W-1:0] fails_inc;
    logic [csb_pkg::COUNT_W-1:0] succ_inc;
    logic                        known_next;
    logic                        allow;
    csb_pkg::entry_t             nxt;

    // Wrapping elapsed time and saturated counter bumps
    assign elapsed   = now - rd_entry.changed_at;
    assign timed_out = elapsed >= {{(csb_pkg::TIME_W-csb_pkg::TIMEOUT_W){1'b0}},
                                   cfg.open_timeout};
    assign fails_inc = csb_pkg::sat_inc(rd_entry.fails);
    assign succ_inc  = csb_pkg::sat_inc(rd_entry.successes);

    // Breaker transitions
    always_comb begin
        nxt        = rd_entry;
        known_next = rd_known;
        allow      = 1'b0;
        wr.en      = 1'b0;
        if (!in_range) begin
            allow = (mode == csb_pkg::MODE_CHECK);
        end else if (!rd_known) begin
            unique case (mode)
                csb_pkg::MODE_CHECK: begin
                    allow = 1'b1;
                end
                csb_pkg::MODE_FAIL: begin
                    known_next     = 1'b1;
                    nxt.state      = csb_pkg::ST_CLOSED;
                    nxt.fails      = {{(csb_pkg::COUNT_W-1){1'b0}}, 1'b1};
                    nxt.successes  = '0;
                    nxt.changed_at = now;
                    wr.en          = 1'b1;
                end
                default: ;
            endcase
        end else begin
            wr.en = 1'b1;
            unique case (mode)
                csb_pkg::MODE_CHECK: begin
                    if (rd_entry.state == csb_pkg::ST_OPEN) begin
                        if (timed_out) begin
                            nxt.state     = csb_pkg::ST_HALF;
                            nxt.fails     = '0;
                            nxt.successes = '0;
                            allow         = 1'b1;
                        end
                    end else begin
                        allow = 1'b1;
                    end
                end
                csb_pkg::MODE_FAIL: begin
                    case (rd_entry.state)
                        csb_pkg::ST_CLOSED: begin
                            nxt.changed_at = now;
                            nxt.fails      = fails_inc;
                            if (fails_inc > cfg.fail_limit) begin
                                nxt.state = csb_pkg::ST_OPEN;
                            end
                        end
                        csb_pkg::ST_HALF: begin
                            nxt.state      = csb_pkg::ST_OPEN;
                            nxt.changed_at = now;
                            nxt.successes  = '0;
                        end
                        default: ;
                    endcase
                end
                csb_pkg::MODE_SUCCESS: begin
                    if (rd_entry.state == csb_pkg::ST_HALF) begin
                        if (succ_inc > cfg.close_limit) begin
                            nxt.state     = csb_pkg::ST_CLOSED;
                            nxt.fails     = '0;
                            nxt.successes = '0;
                        end else begin
                            nxt.successes = succ_inc;
                        end
                    end
                end
                default: ;
            endcase
        end
        wr.entry = nxt;
    end

    // Report the entry after the step; unknown reads as zero counts
    always_comb begin
        result.allow = allow;
        if (in_range && known_next) begin
            result.state     = nxt.state;
            result.fails     = nxt.fails;
            result.successes = nxt.successes;
        end else begin
            result.state     = csb_pkg::ST_UNKNOWN;
            result.fails     = '0;
            result.successes = '0;
        end
    end

endmodule

// ----- hw/rtl/per_service_circuit_breaker_unit.sv -----
// Top level of the per-service circuit breaker: stream ports, config and pipeline.
// Each input word is a check, fail or success report for one service and returns
// one result word. The block sustains one word per clock unless m_tready stalls;
// a word sits in an input register, its table entry is read, updated and written
// back while it sits there, and the result lands in an output register, which
// drives m_tvalid. The single read-modify-write of the entry table per cycle
// sets the rate; since the write lands at the same edge that moves the next word
// in, back-to-back words for one service always see the updated entry. Reset
// clears all entries at once (no clearing pass). Services at or above
// NUM_SERVICES report unknown with zero counts. Configuration writes take effect
// at the next edge and should be made while the block is idle.
`include "assert_macros.svh"

module per_service_circuit_breaker_unit #(
    parameter int NUM_SERVICES = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [csb_pkg::S_TDATA_W-1:0]      s_tdata,  // [3:0] service_id, [35:4] now_seconds
    input  logic [csb_pkg::MODE_W-1:0]         s_tuser,  // [1:0] mode
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [csb_pkg::M_TDATA_W-1:0]      m_tdata,  // [0] allow, [2:1] breaker_state,
                                                         // [10:3] fails_now, [18:11] successes_now
    // configuration writes
    input  logic                               cfg_wr_en,
    input  logic [csb_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [csb_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int TABLE_DEPTH = (NUM_SERVICES < csb_pkg::MAX_SERVICES) ?
                                 NUM_SERVICES : csb_pkg::MAX_SERVICES;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // Config registers
    csb_pkg::cfg_t cfg_reg, cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                csb_pkg::CFG_FAIL_LIMIT:
                    cfg_next.fail_limit = cfg_wdata[csb_pkg::LIMIT_W-1:0];
                csb_pkg::CFG_OPEN_TIMEOUT:
                    cfg_next.open_timeout = cfg_wdata[csb_pkg::TIMEOUT_W-1:0];
                csb_pkg::CFG_CLOSE_LIMIT:
                    cfg_next.close_limit = cfg_wdata[csb_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.fail_limit   <= csb_pkg::FAIL_LIMIT_RST;
            cfg_reg.open_timeout <= csb_pkg::OPEN_TIMEOUT_RST;
            cfg_reg.close_limit  <= csb_pkg::CLOSE_LIMIT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Pipeline handshake
    logic in_valid_reg, in_valid_next;
    logic out_valid_reg, out_valid_next;
    logic adv;
    logic in_take;

    assign adv            = in_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready       = ~in_valid_reg | adv;
    assign in_take        = s_tvalid & s_tready;
    assign in_valid_next  = in_take | (in_valid_reg & ~adv);
    assign out_valid_next = adv | (out_valid_reg & ~m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input word register
    csb_pkg::mode_t                in_mode_reg;
    logic [csb_pkg::SVC_ID_W-1:0]  in_svc_reg;
    logic [csb_pkg::TIME_W-1:0]    in_now_reg;

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_mode_reg <= csb_pkg::mode_t'(s_tuser);
            in_svc_reg  <= s_tdata[csb_pkg::SVC_ID_W-1:0];
            in_now_reg  <= s_tdata[csb_pkg::SVC_ID_W +: csb_pkg::TIME_W];
        end
    end

    // Entry lookup and update
    logic              in_range;
    logic [IDX_W-1:0]  tbl_idx;
    logic              rd_known;
    csb_pkg::entry_t   rd_entry;
    csb_pkg::tbl_wr_t  upd_wr;
    csb_pkg::tbl_wr_t  tbl_wr;
    csb_pkg::result_t  upd_result;

    assign in_range = 32'(in_svc_reg) < NUM_SERVICES;
    assign tbl_idx  = in_svc_reg[IDX_W-1:0];

    csb_table #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W)
    ) u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_idx   (tbl_idx),
        .rd_known (rd_known),
        .rd_entry (rd_entry),
        .wr_idx   (tbl_idx),
        .wr       (tbl_wr)
    );

    csb_update u_update (
        .in_range (in_range),
        .mode     (in_mode_reg),
        .now      (in_now_reg),
        .cfg      (cfg_reg),
        .rd_known (rd_known),
        .rd_entry (rd_entry),
        .wr       (upd_wr),
        .result   (upd_result)
    );

    // Commit only when the word moves on to the output register
    always_comb begin
        tbl_wr    = upd_wr;
        tbl_wr.en = upd_wr.en & adv & in_range;
    end

    // Output word register
    csb_pkg::result_t out_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_reg <= upd_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(csb_pkg::M_TDATA_W - 1 - csb_pkg::STATE_W - 2*csb_pkg::COUNT_W){1'b0}},
                       out_reg.successes, out_reg.fails, out_reg.state, out_reg.allow};

    // Checks
    `CSB_ASSERT(a_allow_only_check, aclk, aresetn,
        adv && (in_mode_reg != csb_pkg::MODE_CHECK) |=> !out_reg.allow,
        "allow set for a report word")
    `CSB_ASSERT(a_fail_creates_entry, aclk, aresetn,
        adv && in_range && (in_mode_reg == csb_pkg::MODE_FAIL) |=>
            (out_reg.state != csb_pkg::ST_UNKNOWN),
        "fail report left entry unknown")
    `CSB_ASSERT(a_unknown_zero_counts, aclk, aresetn,
        out_valid_reg && (out_reg.state == csb_pkg::ST_UNKNOWN) |->
            (out_reg.fails == '0) && (out_reg.successes == '0),
        "unknown entry reported nonzero counts")
    `CSB_ASSERT_ALWAYS(a_reset_empties, aclk,
        !aresetn |=> !m_tvalid && !in_valid_reg,
        "pipeline not empty after reset")

endmodule

// ----- sim/tb_per_service_circuit_breaker_unit.sv -----
// Self-checking testbench for the per-service circuit breaker unit.
`timescale 1ns / 100ps

module tb_per_service_circuit_breaker_unit;

    typedef logic [csb_pkg::MODE_W-1:0]    op_code_t;
    typedef logic [csb_pkg::SVC_ID_W-1:0]  svc_id_t;
    typedef logic [csb_pkg::TIME_W-1:0]    stamp_t;
    typedef logic [csb_pkg::LIMIT_W-1:0]   limit_t;
    typedef logic [csb_pkg::TIMEOUT_W-1:0] timeout_t;
    typedef logic [csb_pkg::COUNT_W-1:0]   count_t;

    localparam int       NUM_SVC     = 16;
    localparam int       CYCLE_LIMIT = 1000000;
    localparam int       LONG_HOLD   = 400;
    localparam int       MAX_PRINTS  = 60;
    localparam op_code_t MODE_UNUSED = 2'd3;
    localparam stamp_t   WRAP_T      = 32'hFFFF_FFF0;

    // one report as offered on the input stream
    typedef struct {
        op_code_t op;
        svc_id_t  svc;
        stamp_t   stamp;
    } report_t;

    logic                                aclk      = 1'b0;
    logic                                aresetn   = 1'b0;
    logic                                s_tvalid  = 1'b0;
    logic                                s_tready;
    logic [csb_pkg::S_TDATA_W-1:0]       s_tdata   = '0;
    logic [csb_pkg::MODE_W-1:0]          s_tuser   = '0;
    logic                                m_tvalid;
    logic                                m_tready  = 1'b0;
    logic [csb_pkg::M_TDATA_W-1:0]       m_tdata;
    logic                                cfg_wr_en = 1'b0;
    logic [csb_pkg::CFG_ADDR_W-1:0]      cfg_addr  = '0;
    logic [csb_pkg::CFG_DATA_W-1:0]      cfg_wdata = '0;

    // breaker table and limits as the block should hold them
    logic                    svc_known [NUM_SVC];
    csb_pkg::brk_state_t     svc_state [NUM_SVC];
    count_t                  svc_fails [NUM_SVC];
    count_t                  svc_succ  [NUM_SVC];
    stamp_t                  svc_since [NUM_SVC];
    limit_t                  lim_fail;
    timeout_t                lim_timeout;
    limit_t                  lim_succ;

    report_t                 pending_reports[$];
    csb_pkg::result_t        verdict_q[$];
    report_t                 on_bus;
    csb_pkg::result_t        want;

    stamp_t                  gen_time;
    stamp_t                  trip_at [NUM_SVC];
    int                      reports_made = 0;
    int                      words_out    = 0;
    int                      mismatches   = 0;
    int                      cycle_count  = 0;
    int                      sender_gap   = 0;
    int                      sink_hold    = 0;
    int                      driver_calm  = 0;
    int                      sink_calm    = 0;
    bit                      long_hold_done = 1'b0;

    per_service_circuit_breaker_unit #(.NUM_SERVICES(NUM_SVC)) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // [3:0] service_id, [35:4] now_seconds
        .s_tuser   (s_tuser),   // [1:0] mode
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // [0] allow, [2:1] breaker_state,
                                // [10:3] fails_now, [18:11] successes_now
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #1 aclk = ~aclk;

    // apply one report to the table copy and return the verdict it yields
    function automatic csb_pkg::result_t breaker_step(op_code_t op, svc_id_t svc,
                                                      stamp_t stamp);
        csb_pkg::result_t v;
        stamp_t           waited;
        v.allow     = 1'b0;
        v.state     = csb_pkg::ST_UNKNOWN;
        v.fails     = '0;
        v.successes = '0;
        if (!svc_known[svc]) begin
            if (op == csb_pkg::MODE_CHECK) begin
                v.allow = 1'b1;
            end else if (op == csb_pkg::MODE_FAIL) begin
                svc_known[svc] = 1'b1;
                svc_state[svc] = csb_pkg::ST_CLOSED;
                svc_fails[svc] = 8'd1;
                svc_succ[svc]  = '0;
                svc_since[svc] = stamp;
            end
        end else if (op == csb_pkg::MODE_CHECK) begin
            if (svc_state[svc] == csb_pkg::ST_OPEN) begin
                waited = stamp - svc_since[svc];
                if (waited >= {16'b0, lim_timeout}) begin
                    svc_state[svc] = csb_pkg::ST_HALF;
                    svc_fails[svc] = '0;
                    svc_succ[svc]  = '0;
                    v.allow = 1'b1;
                end
            end else begin
                v.allow = 1'b1;
            end
        end else if (op == csb_pkg::MODE_FAIL) begin
            if (svc_state[svc] == csb_pkg::ST_CLOSED) begin
                svc_since[svc] = stamp;
                if (svc_fails[svc] != 8'hFF) svc_fails[svc] = svc_fails[svc] + 8'd1;
                if (svc_fails[svc] > lim_fail) svc_state[svc] = csb_pkg::ST_OPEN;
            end else if (svc_state[svc] == csb_pkg::ST_HALF) begin
                svc_state[svc] = csb_pkg::ST_OPEN;
                svc_since[svc] = stamp;
                svc_succ[svc]  = '0;
            end
        end else if (op == csb_pkg::MODE_SUCCESS) begin
            if (svc_state[svc] == csb_pkg::ST_HALF) begin
                if (svc_succ[svc] != 8'hFF) svc_succ[svc] = svc_succ[svc] + 8'd1;
                if (svc_succ[svc] > lim_succ) begin
                    svc_state[svc] = csb_pkg::ST_CLOSED;
                    svc_fails[svc] = '0;
                    svc_succ[svc]  = '0;
                end
            end
        end
        if (svc_known[svc]) begin
            v.state     = svc_state[svc];
            v.fails     = svc_fails[svc];
            v.successes = svc_succ[svc];
        end
        return v;
    endfunction

    // idle length: mostly short, a few long, with occasional calm stretches
    function automatic int pick_idle(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("mismatch at result word %0d: %s got %0d expected %0d",
                     words_out, what, got, exp_val);
    endtask

    task automatic queue_report(op_code_t op, svc_id_t svc, stamp_t stamp);
        report_t r;
        r.op    = op;
        r.svc   = svc;
        r.stamp = stamp;
        pending_reports.push_back(r);
        reports_made++;
    endtask

    task automatic write_reg(csb_pkg::cfg_addr_t idx, logic [csb_pkg::CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            csb_pkg::CFG_FAIL_LIMIT:   lim_fail    = val[csb_pkg::LIMIT_W-1:0];
            csb_pkg::CFG_OPEN_TIMEOUT: lim_timeout = val;
            csb_pkg::CFG_CLOSE_LIMIT:  lim_succ    = val[csb_pkg::LIMIT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_limits(limit_t f, timeout_t t, limit_t s);
        write_reg(csb_pkg::CFG_FAIL_LIMIT, {8'b0, f});
        write_reg(csb_pkg::CFG_OPEN_TIMEOUT, t);
        write_reg(csb_pkg::CFG_CLOSE_LIMIT, {8'b0, s});
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        repeat (2) @(posedge aclk);
    endtask

    // hold the sender until every queued report has been answered
    task automatic wait_idle();
        while (words_out < reports_made) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // probe around the timeout, then walk the half-open state toward closed
    task automatic recover_service(svc_id_t s);
        stamp_t base;
        int     m;
        base = trip_at[s];
        if (lim_timeout != 0) queue_report(csb_pkg::MODE_CHECK, s, base + lim_timeout - 1);
        base = base + lim_timeout + $urandom_range(0, 2);
        queue_report(csb_pkg::MODE_CHECK, s, base);
        m = (lim_succ < 10) ? lim_succ + 1 : $urandom_range(1, 6);
        repeat (m) begin
            base += $urandom_range(0, 2);
            if ($urandom_range(0, 9) == 0) begin
                queue_report(csb_pkg::MODE_FAIL, s, base);
                trip_at[s] = base;
            end else begin
                queue_report(csb_pkg::MODE_SUCCESS, s, base);
            end
        end
        gen_time = base;
    endtask

    // mostly trip/recover sequences, with scattered ops and raw noise
    task automatic random_traffic(int n);
        int      target;
        int      pick;
        int      k;
        svc_id_t s;
        target = reports_made + n;
        while (reports_made < target) begin
            pick = $urandom_range(0, 99);
            s    = svc_id_t'($urandom_range(0, NUM_SVC - 1));
            if (pick < 15) begin
                queue_report(op_code_t'($urandom_range(0, 3)), s, $urandom());
            end else if (pick < 50) begin
                k = (lim_fail < 10) ? lim_fail + 1 : $urandom_range(1, 6);
                repeat (k) begin
                    gen_time += $urandom_range(0, 3);
                    queue_report(csb_pkg::MODE_FAIL, s, gen_time);
                end
                trip_at[s] = gen_time;
                if ($urandom_range(0, 9) < 7) recover_service(s);
            end else if (pick < 70) begin
                recover_service(s);
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    gen_time += $urandom_range(0, lim_timeout + 5);
                    queue_report(($urandom_range(0, 9) == 0) ? MODE_UNUSED :
                                 op_code_t'($urandom_range(0, 2)), s, gen_time);
                end
            end
        end
    endtask

    // input driver: one word offered at a time, held until accepted
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (!s_tvalid || s_tready) begin
                if (s_tvalid) begin
                    verdict_q.push_back(breaker_step(on_bus.op, on_bus.svc, on_bus.stamp));
                    sender_gap = pick_idle(driver_calm);
                end
                if (sender_gap > 0) begin
                    sender_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_reports.size() != 0) begin
                    on_bus = pending_reports.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {4'b0, on_bus.stamp, on_bus.svc};
                    s_tuser  <= on_bus.op;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor with receiver stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (verdict_q.size() == 0) begin
                    flag_mismatch("unexpected word", 32'(m_tdata), 32'd0);
                end else begin
                    want = verdict_q.pop_front();
                    if (m_tdata[0] !== want.allow)
                        flag_mismatch("allow", 32'(m_tdata[0]), 32'(want.allow));
                    if (m_tdata[2:1] !== want.state)
                        flag_mismatch("breaker_state", 32'(m_tdata[2:1]), 32'(want.state));
                    if (m_tdata[10:3] !== want.fails)
                        flag_mismatch("fails_now", 32'(m_tdata[10:3]), 32'(want.fails));
                    if (m_tdata[18:11] !== want.successes)
                        flag_mismatch("successes_now", 32'(m_tdata[18:11]),
                                      32'(want.successes));
                end
                words_out++;
                sink_hold = pick_idle(sink_calm);
            end
            // one long hold-off while the sender still has plenty queued
            if (!long_hold_done && words_out > 100 && pending_reports.size() > 100) begin
                long_hold_done = 1'b1;
                sink_hold = LONG_HOLD;
            end
            if (sink_hold > 0) begin
                sink_hold--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_per_service_circuit_breaker_unit NOT OK");
            $finish;
        end
    end

    initial begin
        int      i;
        svc_id_t s;
        for (i = 0; i < NUM_SVC; i++) begin
            svc_known[i] = 1'b0;
            svc_state[i] = csb_pkg::ST_CLOSED;
            svc_fails[i] = '0;
            svc_succ[i]  = '0;
            svc_since[i] = '0;
            trip_at[i]   = '0;
        end
        lim_fail    = csb_pkg::FAIL_LIMIT_RST;
        lim_timeout = csb_pkg::OPEN_TIMEOUT_RST;
        lim_succ    = csb_pkg::CLOSE_LIMIT_RST;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: unknown entries, open across the time wrap, half-open both ways
        queue_report(csb_pkg::MODE_CHECK, 4'd0, 32'd0);
        queue_report(csb_pkg::MODE_SUCCESS, 4'd1, 32'd7);
        queue_report(MODE_UNUSED, 4'd2, 32'd9);
        repeat (csb_pkg::FAIL_LIMIT_RST + 1) queue_report(csb_pkg::MODE_FAIL, 4'd15, WRAP_T);
        queue_report(csb_pkg::MODE_SUCCESS, 4'd15, WRAP_T + 1);
        queue_report(csb_pkg::MODE_FAIL, 4'd15, WRAP_T + 8);
        queue_report(csb_pkg::MODE_CHECK, 4'd15, WRAP_T + csb_pkg::OPEN_TIMEOUT_RST - 1);
        queue_report(csb_pkg::MODE_CHECK, 4'd15, WRAP_T + csb_pkg::OPEN_TIMEOUT_RST);
        queue_report(MODE_UNUSED, 4'd15, 32'h10);
        repeat (2) queue_report(csb_pkg::MODE_SUCCESS, 4'd15, 32'h11);
        queue_report(csb_pkg::MODE_FAIL, 4'd15, 32'h20);
        queue_report(csb_pkg::MODE_CHECK, 4'd15, 32'h20 + csb_pkg::OPEN_TIMEOUT_RST);
        repeat (csb_pkg::CLOSE_LIMIT_RST + 1)
            queue_report(csb_pkg::MODE_SUCCESS, 4'd15, 32'h40);
        queue_report(csb_pkg::MODE_CHECK, 4'd15, 32'h41);
        queue_report(csb_pkg::MODE_SUCCESS, 4'd15, 32'h42);
        queue_report(csb_pkg::MODE_FAIL, 4'd0, 32'hFFFF_FFFF);
        wait_idle();

        // reset limits, time starting just below the wrap
        gen_time = 32'hFFFF_FF00;
        random_traffic(300);
        wait_idle();

        // lowest limits: every fail opens, every check of an open entry half-opens, one success closes
        set_limits(8'd0, 16'd0, 8'd0);
        random_traffic(200);
        wait_idle();

        // highest limits: walk one service through full counts and the longest timeout
        set_limits(8'd254, 16'hFFFF, 8'd254);
        s = 4'd5;
        if (svc_known[s] && svc_state[s] != csb_pkg::ST_CLOSED) begin
            queue_report(csb_pkg::MODE_CHECK, s, svc_since[s] + 32'hFFFF);
            repeat (255) queue_report(csb_pkg::MODE_SUCCESS, s, gen_time);
        end
        gen_time += 1;
        repeat (255) queue_report(csb_pkg::MODE_FAIL, s, gen_time);
        queue_report(csb_pkg::MODE_CHECK, s, gen_time + 32'hFFFE);
        queue_report(csb_pkg::MODE_CHECK, s, gen_time + 32'hFFFF);
        repeat (255) queue_report(csb_pkg::MODE_SUCCESS, s, gen_time + 32'h10000);
        queue_report(csb_pkg::MODE_CHECK, s, gen_time + 32'h10001);
        gen_time += 32'h10002;
        random_traffic(80);
        wait_idle();

        // moderate random limits
        set_limits(limit_t'($urandom_range(1, 5)), timeout_t'($urandom_range(1, 200)),
                   limit_t'($urandom_range(1, 5)));
        random_traffic(250);
        wait_idle();
        repeat (10) @(posedge aclk);

        if (verdict_q.size() != 0)
            flag_mismatch("results missing", 32'd0, 32'(verdict_q.size()));
        if (mismatches == 0) begin
            $display("tb_per_service_circuit_breaker_unit OK");
        end else begin
            $display("tb_per_service_circuit_breaker_unit NOT OK");
        end
        $finish;
    end

endmodule
